// ===== src/frame_history_select_blend_weight_macros.svh =====
// Assertion helpers for the checker file.
`ifndef FRAME_HISTORY_SELECT_BLEND_WEIGHT_MACROS_SVH
`define FRAME_HISTORY_SELECT_BLEND_WEIGHT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FHSBW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fhsbw assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FHSBW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fhsbw assertion failed");

`endif

// ===== src/fhsbw_pkg.sv =====
package fhsbw_pkg;

   localparam int NUM_FRAMES  = 4;
   localparam int SLOT_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W       = $clog2(NUM_FRAMES + 1);
   localparam int TS_W        = 48;
   localparam int WEIGHT_W    = 16;
   localparam int DIV_STEPS   = WEIGHT_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int OUT_SLOT_W  = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [TS_W-1:0]     stamp_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_PRESENT = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_ENABLE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_THRESHOLD = 1'b1;

   localparam weight_type          THRESHOLD_RESET = 16'd58982;
   localparam weight_type          WEIGHT_HALF     = 16'h8000;
   localparam logic [WEIGHT_W:0]   WEIGHT_ONE      = 17'h10000;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_BEFORE = 2'd1,
      ACT_AFTER  = 2'd2,
      ACT_BLEND  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BDIFF,
      ST_SPAN,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Control from the sequencer to the frame store.
   typedef struct packed {
      logic      wr_en;
      stamp_type wr_time;
      logic      rd_en;
      slot_type  rd_slot;
   } store_ctrl_type;

   // Registered read result from the frame store.
   typedef struct packed {
      logic      live;
      logic      valid;
      slot_type  slot;
      stamp_type stamp;
   } store_read_type;

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic [1:0]            pad;
      weight_type            blend_weight;
      logic [OUT_SLOT_W-1:0] after_slot;
      logic [OUT_SLOT_W-1:0] before_slot;
      action_type            action;
   } rsp_data_type;

endpackage

// ===== src/fhsbw_frame_store.sv =====
module fhsbw_frame_store
   import fhsbw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  store_ctrl_type ctrl,
   output store_read_type rd
);

   stamp_type             mem [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] valid_ff;
   slot_type              wr_slot_ff;
   slot_type              wr_slot_in;
   logic                  live_ff;
   logic                  rd_valid_ff;
   slot_type              rd_slot_ff;
   stamp_type             rd_time_ff;

   assign wr_slot_in = (wr_slot_ff == slot_type'(NUM_FRAMES - 1)) ? '0 : wr_slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         wr_slot_ff <= '0;
         live_ff    <= 1'b0;
      end else begin
         live_ff <= ctrl.rd_en;
         if (ctrl.wr_en) begin
            valid_ff[wr_slot_ff] <= 1'b1;
            wr_slot_ff           <= wr_slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_slot_ff] <= ctrl.wr_time;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_time_ff  <= mem[ctrl.rd_slot];
         rd_valid_ff <= valid_ff[ctrl.rd_slot];
         rd_slot_ff  <= ctrl.rd_slot;
      end
   end

   assign rd.live  = live_ff;
   assign rd.valid = rd_valid_ff;
   assign rd.slot  = rd_slot_ff;
   assign rd.stamp = rd_time_ff;

endmodule

// ===== src/frame_history_select_blend_weight.sv =====
// A store request gives no response, and stores may go back to back.
// A present request scans one slot per cycle and then gives its response; with both frames
// found and blending enabled, 16 restoring divide steps first run on the shared subtractor.
// The next request is taken as the response appears, or later while an earlier response is
// still held by the receiver.
// Synchronous active-high reset empties the ring and restores the register defaults.
module frame_history_select_blend_weight
   import fhsbw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [47:0] time_stamp
   input  logic                   req_tuser,   // [0] operation
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // action, before_slot, after_slot,
                                               // blend_weight, zero pad
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type      state_ff, state_in;
   store_ctrl_type store_ctrl;
   store_read_type store_rd;

   logic [CNT_W-1:0]  cnt_ff;
   stamp_type         target_ff;
   logic              has_b_ff, has_a_ff;
   slot_type          b_slot_ff, a_slot_ff;
   stamp_type         b_time_ff, a_time_ff;
   stamp_type         rem_ff, span_ff;
   weight_type        quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              half_ff;
   logic              enable_ff;
   weight_type        thresh_ff;
   logic              rsp_valid_ff;
   rsp_data_type      rsp_ff, rsp_in;

   logic              accept_present;
   logic              scan_done;
   logic              both_blend;
   logic              rsp_free;
   logic [TS_W:0]     sub_a, sub_b;
   logic [TS_W+1:0]   sub_res;
   logic              sub_borrow;
   logic              span_bad;
   weight_type        weight;

   fhsbw_frame_store u_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (store_ctrl),
      .rd    (store_rd)
   );

   assign accept_present = req_tvalid && req_tready && (req_tuser == OP_PRESENT);
   assign scan_done      = (cnt_ff == CNT_W'(NUM_FRAMES));
   assign both_blend     = has_b_ff && has_a_ff && enable_ff;
   assign rsp_free       = !rsp_valid_ff || rsp_tready;

   // The one subtractor; its operands follow the sequencer state.
   assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_res[TS_W+1];
   assign span_bad   = sub_borrow || (sub_res[TS_W-1:0] == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_present) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_BDIFF;
         end
         ST_BDIFF: begin
            state_in = both_blend ? ST_SPAN : ST_FINISH;
         end
         ST_SPAN: begin
            state_in = span_bad ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready         = (state_ff == ST_IDLE);
      store_ctrl.wr_en   = req_tvalid && (state_ff == ST_IDLE) && (req_tuser == OP_STORE);
      store_ctrl.wr_time = req_tdata[TS_W-1:0];
      store_ctrl.rd_en   = (state_ff == ST_SCAN) && !scan_done;
      store_ctrl.rd_slot = cnt_ff[SLOT_W-1:0];
      sub_a              = {1'b0, target_ff};
      sub_b              = {1'b0, b_time_ff};
      unique case (state_ff)
         ST_SPAN: begin
            sub_a = {1'b0, a_time_ff};
         end
         ST_DIVIDE: begin
            sub_a = {rem_ff, 1'b0};
            sub_b = {1'b0, span_ff};
         end
         default: begin
         end
      endcase
   end

   // Final decision, evaluated in the finish state.
   always_comb begin
      weight             = half_ff ? WEIGHT_HALF : quo_ff;
      rsp_in.pad         = '0;
      rsp_in.before_slot = has_b_ff ? OUT_SLOT_W'(b_slot_ff) : '0;
      rsp_in.after_slot  = has_a_ff ? OUT_SLOT_W'(a_slot_ff) : '0;
      rsp_in.blend_weight = '0;
      rsp_in.action      = ACT_NONE;
      priority if (both_blend) begin
         priority if ({1'b0, weight} < (WEIGHT_ONE - {1'b0, thresh_ff})) begin
            rsp_in.action = ACT_BEFORE;
         end else if (weight > thresh_ff) begin
            rsp_in.action = ACT_AFTER;
         end else begin
            rsp_in.action       = ACT_BLEND;
            rsp_in.blend_weight = weight;
         end
      end else if (has_b_ff) begin
         rsp_in.action = ACT_BEFORE;
      end else if (has_a_ff) begin
         rsp_in.action = ACT_AFTER;
      end else begin
         rsp_in.action = ACT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         has_b_ff     <= 1'b0;
         has_a_ff     <= 1'b0;
         step_ff      <= '0;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         thresh_ff    <= THRESHOLD_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_BLEND_ENABLE:    enable_ff <= csr_wdata[0];
               CSR_BLEND_THRESHOLD: thresh_ff <= csr_wdata[WEIGHT_W-1:0];
            endcase
         end
         if (accept_present) begin
            cnt_ff   <= '0;
            has_b_ff <= 1'b0;
            has_a_ff <= 1'b0;
            half_ff  <= 1'b0;
         end
         if (store_ctrl.rd_en) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         // Nearest before is the latest stamp not past the target, nearest after
         // the earliest stamp past it; strict compares keep the lower slot on ties.
         if ((state_ff == ST_SCAN) && store_rd.live && store_rd.valid) begin
            if (store_rd.stamp <= target_ff) begin
               if (!has_b_ff || (store_rd.stamp > b_time_ff)) begin
                  has_b_ff <= 1'b1;
               end
            end else if (!has_a_ff || (store_rd.stamp < a_time_ff)) begin
               has_a_ff <= 1'b1;
            end
         end
         if (state_ff == ST_SPAN) begin
            half_ff <= span_bad;
            step_ff <= '0;
         end
         if (state_ff == ST_DIVIDE) begin
            step_ff <= step_ff + 1'b1;
         end
         if ((state_ff == ST_FINISH) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_present) begin
         target_ff <= req_tdata[TS_W-1:0];
      end
      if ((state_ff == ST_SCAN) && store_rd.live && store_rd.valid) begin
         if (store_rd.stamp <= target_ff) begin
            if (!has_b_ff || (store_rd.stamp > b_time_ff)) begin
               b_time_ff <= store_rd.stamp;
               b_slot_ff <= store_rd.slot;
            end
         end else if (!has_a_ff || (store_rd.stamp < a_time_ff)) begin
            a_time_ff <= store_rd.stamp;
            a_slot_ff <= store_rd.slot;
         end
      end
      if (state_ff == ST_BDIFF) begin
         rem_ff <= sub_res[TS_W-1:0];
         quo_ff <= '0;
      end
      if (state_ff == ST_SPAN) begin
         span_ff <= sub_res[TS_W-1:0];
      end
      // Restoring divide: the remainder stays below the span, so 48 bits hold it.
      if (state_ff == ST_DIVIDE) begin
         if (sub_borrow) begin
            rem_ff <= {rem_ff[TS_W-2:0], 1'b0};
            quo_ff <= {quo_ff[WEIGHT_W-2:0], 1'b0};
         end else begin
            rem_ff <= sub_res[TS_W-1:0];
            quo_ff <= {quo_ff[WEIGHT_W-2:0], 1'b1};
         end
      end
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

// ===== src/fhsbw_checker.sv =====
`include "frame_history_select_blend_weight_macros.svh"

module fhsbw_checker
   import fhsbw_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_DATA_W-1:0]  req_tdata,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic                   csr_we,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata
);

   rsp_data_type rsp_view;
   logic         req_take;

   assign rsp_view = rsp_data_type'(rsp_tdata);
   assign req_take = req_tvalid && req_tready;

   // A stalled response keeps its contents.
   `FHSBW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // A present request occupies the block; a store does not.
   `FHSBW_ASSERT_NEXT(a_present_busy, clock, reset, req_take && (req_tuser == OP_PRESENT),
      !req_tready)
   `FHSBW_ASSERT_NEXT(a_store_quick, clock, reset, req_take && (req_tuser == OP_STORE),
      req_tready)

   // The weight is only carried by a blend, and no frame means no slots.
   `FHSBW_ASSERT_NOW(a_rsp_fields, clock, reset, rsp_tvalid,
      ((rsp_view.action == ACT_BLEND) || (rsp_view.blend_weight == '0)) &&
      ((rsp_view.action != ACT_NONE) ||
       ((rsp_view.before_slot == '0) && (rsp_view.after_slot == '0))))

endmodule

bind frame_history_select_blend_weight fhsbw_checker u_fhsbw_checker (.*);

// ===== verif/frame_history_select_blend_weight_tb.sv =====
module frame_history_select_blend_weight_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fhsbw_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_SHOWN     = 10;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // [47:0] time_stamp
   logic                   req_tuser;   // [0] operation
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // action, before_slot, after_slot, blend_weight
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Shadow of the frame ring and the registers.
   stamp_type   frame_stamp [NUM_FRAMES];
   logic        frame_live  [NUM_FRAMES];
   int unsigned next_slot;
   logic        blend_on;
   weight_type  blend_limit;

   rsp_data_type pending_choices[$];
   rsp_data_type seen_choice;
   rsp_data_type want_choice;
   int           bad_count;
   bit           idle_on;
   int           rsp_hold;
   int           stall_left;

   // Capture stream used to build realistic frame histories.
   stamp_type capture_clock;
   stamp_type capture_step;

   frame_history_select_blend_weight i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("frame_history_select_blend_weight regression: fail");
      $finish;
   end

   function automatic stamp_type rand_stamp();
      return stamp_type'({$urandom(), $urandom()});
   endfunction

   task automatic record_capture(input stamp_type stamp);
      frame_stamp[next_slot] = stamp;
      frame_live[next_slot]  = 1'b1;
      next_slot = (next_slot == NUM_FRAMES - 1) ? 0 : next_slot + 1;
   endtask

   // Nearest frame at or before the target and nearest after it; the lowest
   // slot wins a tie because only a strictly closer frame replaces the pick.
   function automatic rsp_data_type choose_frames(input stamp_type target);
      rsp_data_type       r;
      logic               have_before;
      logic               have_after;
      int                 before_idx;
      int                 after_idx;
      stamp_type          before_gap;
      stamp_type          after_gap;
      stamp_type          gap;
      logic [63:0]        quot;
      logic [WEIGHT_W:0]  low_edge;
      r           = '0;
      have_before = 1'b0;
      have_after  = 1'b0;
      before_idx  = 0;
      after_idx   = 0;
      before_gap  = '0;
      after_gap   = '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         if (frame_live[i]) begin
            if (frame_stamp[i] <= target) begin
               gap = target - frame_stamp[i];
               if (!have_before || gap < before_gap) begin
                  have_before = 1'b1;
                  before_gap  = gap;
                  before_idx  = i;
               end
            end else begin
               gap = frame_stamp[i] - target;
               if (!have_after || gap < after_gap) begin
                  have_after = 1'b1;
                  after_gap  = gap;
                  after_idx  = i;
               end
            end
         end
      end
      if (have_before && have_after && blend_on) begin
         if (frame_stamp[after_idx] > frame_stamp[before_idx]) begin
            quot = {before_gap, 16'h0000} /
                   (frame_stamp[after_idx] - frame_stamp[before_idx]);
         end else begin
            quot = WEIGHT_HALF;
         end
         if (quot > 64'hFFFF) begin
            quot = 64'hFFFF;
         end
         low_edge = WEIGHT_ONE - blend_limit;
         // The copy-before test is applied first, so it wins when the
         // threshold lies below one half and both tests hold.
         if (quot < low_edge) begin
            r.action = ACT_BEFORE;
         end else if (quot > blend_limit) begin
            r.action = ACT_AFTER;
         end else begin
            r.action       = ACT_BLEND;
            r.blend_weight = quot[WEIGHT_W-1:0];
         end
      end else if (have_before) begin
         r.action = ACT_BEFORE;
      end else if (have_after) begin
         r.action = ACT_AFTER;
      end else begin
         r.action = ACT_NONE;
      end
      r.before_slot = have_before ? OUT_SLOT_W'(before_idx) : '0;
      r.after_slot  = have_after ? OUT_SLOT_W'(after_idx) : '0;
      return r;
   endfunction

   task automatic note_failure(input string text);
      bad_count++;
      if (bad_count <= MAX_SHOWN) begin
         $display("%t: %s", $realtime, text);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_choice = rsp_data_type'(rsp_tdata);
         if (pending_choices.size() == 0) begin
            note_failure($sformatf("response with no present request waiting: %h",
                                   rsp_tdata));
         end else begin
            want_choice = pending_choices.pop_front();
            if (seen_choice.action !== want_choice.action ||
                seen_choice.before_slot !== want_choice.before_slot ||
                seen_choice.after_slot !== want_choice.after_slot ||
                seen_choice.blend_weight !== want_choice.blend_weight) begin
               note_failure($sformatf({"mismatch: expected action %0d before %0d ",
                  "after %0d weight %0d, got action %0d before %0d after %0d ",
                  "weight %0d"},
                  want_choice.action, want_choice.before_slot,
                  want_choice.after_slot, want_choice.blend_weight,
                  seen_choice.action, seen_choice.before_slot,
                  seen_choice.after_slot, seen_choice.blend_weight));
            end
         end
      end
   end

   // Response ready: random stall bursts, or one long hold when a test asks.
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            stall_left = rsp_hold;
            rsp_hold   = 0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Valid is left high after a handshake unless a gap follows; the next
   // request or a drain changes it at the following falling edge.
   task automatic send_request(input logic op, input stamp_type stamp);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= stamp;
      do @(posedge clock); while (!req_tready);
      if (op == OP_PRESENT) begin
         pending_choices.push_back(choose_frames(stamp));
      end else begin
         record_capture(stamp);
      end
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_responses();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_BLEND_ENABLE) begin
         blend_on = value[0];
      end else begin
         blend_limit = value;
      end
   endtask

   task automatic pick_settings();
      write_register(CSR_BLEND_ENABLE, CSR_DATA_W'($urandom_range(0, 3) != 0));
      case ($urandom_range(0, 7))
         0: write_register(CSR_BLEND_THRESHOLD, CSR_DATA_W'($urandom_range(0, 32767)));
         1: write_register(CSR_BLEND_THRESHOLD, 16'd32768);
         2: write_register(CSR_BLEND_THRESHOLD, 16'd65535);
         default: write_register(CSR_BLEND_THRESHOLD,
                                 CSR_DATA_W'($urandom_range(32768, 65535)));
      endcase
   endtask

   function automatic stamp_type pick_capture_step();
      case ($urandom_range(0, 3))
         0: return stamp_type'($urandom_range(0, 16));
         1: return stamp_type'($urandom_range(1, 100000));
         2: return rand_stamp() >> $urandom_range(8, 47);
         default: return rand_stamp() >> $urandom_range(1, 47);
      endcase
   endfunction

   // Mostly a steady capture stream with presents landing among the recent
   // frames; the rest is stray requests anywhere in the time range.
   task automatic capture_item();
      int          pick;
      int          slot;
      logic [63:0] reach;
      stamp_type   target;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         capture_clock = rand_stamp();
         capture_step  = pick_capture_step();
         send_request(OP_STORE, capture_clock);
      end else if (pick < 12) begin
         send_request(logic'($urandom_range(0, 1)), rand_stamp());
      end else if (pick < 42) begin
         if ($urandom_range(0, 9) == 0) begin
            capture_step = pick_capture_step();
         end
         capture_clock = capture_clock + capture_step;
         send_request(OP_STORE, capture_clock);
      end else if (pick < 50) begin
         slot   = $urandom_range(0, NUM_FRAMES - 1);
         target = frame_live[slot] ? frame_stamp[slot] : rand_stamp();
         send_request(OP_PRESENT, target);
      end else begin
         reach  = (64'(capture_step) * $urandom_range(0, 400)) / 100;
         target = capture_clock + capture_step - stamp_type'(reach);
         send_request(OP_PRESENT, target);
      end
   endtask

   task automatic test_empty_ring();
      send_request(OP_PRESENT, '0);
      send_request(OP_PRESENT, '1);
   endtask

   task automatic test_single_frame();
      send_request(OP_STORE, 48'd1000);
      send_request(OP_PRESENT, 48'd999);
      send_request(OP_PRESENT, 48'd1000);
      send_request(OP_PRESENT, 48'h7FFF_FFFF_FFFF);
   endtask

   // Two slots hold the same time, and the time range ends are stored.
   task automatic test_ties_and_extremes();
      send_request(OP_STORE, '0);
      send_request(OP_STORE, '1);
      send_request(OP_STORE, 48'd1000);
      send_request(OP_PRESENT, 48'd1000);
      send_request(OP_PRESENT, '1);
   endtask

   task automatic test_blend_window();
      write_register(CSR_BLEND_ENABLE, 16'd1);
      send_request(OP_PRESENT, '0);
      send_request(OP_PRESENT, 48'd999);
      send_request(OP_PRESENT, 48'd500);
      send_request(OP_PRESENT, 48'd100);
      send_request(OP_PRESENT, 48'd101);
      send_request(OP_PRESENT, 48'h8000_0000_0000);
      // The pointer has wrapped, so this overwrites the oldest slot.
      send_request(OP_STORE, 48'd5);
      send_request(OP_PRESENT, 48'd3);
   endtask

   task automatic test_thresholds();
      logic [CSR_DATA_W-1:0] limits [5];
      limits = '{16'd32768, 16'd65535, 16'd0, 16'd20000, THRESHOLD_RESET};
      foreach (limits[k]) begin
         write_register(CSR_BLEND_THRESHOLD, limits[k]);
         repeat (30) capture_item();
      end
   endtask

   task automatic test_blend_disabled();
      write_register(CSR_BLEND_ENABLE, 16'd0);
      repeat (60) capture_item();
      write_register(CSR_BLEND_ENABLE, 16'd1);
   endtask

   // The response side holds off while presents keep coming, so the block
   // fills up and stops taking requests; then the sender waits it out.
   task automatic test_backpressure();
      rsp_hold = 400;
      repeat (12) begin
         capture_clock = capture_clock + capture_step;
         send_request(OP_STORE, capture_clock);
         send_request(OP_PRESENT, capture_clock - (capture_step >> 1));
      end
      drain_responses();
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 250 == 0) begin
            pick_settings();
         end
         if (n % 100 == 0) begin
            idle_on = (count - n > 200) && ($urandom_range(0, 3) != 0);
         end
         capture_item();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      idle_on    = 1'b1;
      rsp_hold   = 0;
      bad_count  = 0;
      next_slot  = 0;
      blend_on   = 1'b0;
      blend_limit   = THRESHOLD_RESET;
      capture_clock = 48'd1000;
      capture_step  = 48'd33;
      foreach (frame_live[k]) begin
         frame_live[k]  = 1'b0;
         frame_stamp[k] = '0;
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_empty_ring();
      test_single_frame();
      test_ties_and_extremes();
      test_blend_window();
      test_thresholds();
      test_blend_disabled();
      test_backpressure();
      test_random_traffic(1000);
      drain_responses();

      if (bad_count == 0) begin
         $display("frame_history_select_blend_weight regression: pass");
      end else begin
         $display("frame_history_select_blend_weight regression: fail");
      end
      $finish;
   end

endmodule
